// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Hue is in 1/16 degree, so one 60 degree sector spans 960 units.
    localparam int unsigned HUE_W        = 13;
    localparam int unsigned CH_W         = 8;
    localparam int unsigned SECTOR_UNITS = 960;
    localparam int unsigned FULL_TURN    = 5760;

    // Channel scale D = 255 * 960; scaled numerator fits 26 bits.
    localparam int unsigned SCALE_D = 255 * SECTOR_UNITS;
    localparam int unsigned A_W     = 18;   // D - S*j, at most D
    localparam int unsigned NUM_W   = 26;   // V*(D - S*j) + D/2

    // Reciprocal of D for the constant divide: q ~= (x * RECIP) >> RECIP_SHIFT.
    // Estimate is q or q-1; one compare and add fixes it.
    localparam int unsigned RECIP_SHIFT = 44;
    localparam int unsigned RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SCALE_D));

    // Sector code: which channel carries chroma / secondary / nothing.
    typedef enum logic [2:0] {
        SEC_RGB = 3'd0,     // R chroma, G secondary, B empty
        SEC_GRB = 3'd1,
        SEC_GBR = 3'd2,
        SEC_BGR = 3'd3,
        SEC_BRG = 3'd4,
        SEC_RBG = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

endpackage

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage pipelined HSV to 8-bit RGB pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_hsv and raise start; the beat is taken on any
//   rising edge where start is high and busy is low. busy is high only
//   during reset and the first cycle after it; afterwards it stays low, so
//   a new pixel may enter on every clock.
//   Output channel: o_done pulses for one cycle with the pixel on o_rgb.
//   The receiver has no backpressure and must take the beat in that cycle.
//   Throughput: one pixel per clock.
//   Pipeline: sector decode | S*j | V*(D-S*j) | reciprocal multiply |
//   quotient fix-up and channel mux. The reciprocal multiply (26x27 bits)
//   sets the stage balance.
//   Reset (i_rst_n low, synchronous) clears all valid bits; pixels in
//   flight are dropped and no result beat is produced for them.
//   Hues of 360 degrees and above wrap once by 360 degrees.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_hsv i_hsv,
    output logic busy,
    output logic o_done,
    output t_rgb o_rgb
);

    localparam int unsigned J_W = 10;   // j in 0..960
    localparam int unsigned NL  = 2;    // lanes: 0 secondary, 1 empty

    // ---------------- control: busy and valid chain ----------------
    logic       r_busy;
    logic [4:0] r_vld;
    logic       accept;

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign o_done = r_vld[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[3:0], accept};
        end
    end

    // ---------------- stage 1: wrap hue, find sector and j ----------------
    logic [HUE_W-1:0] n_hw;
    t_sector          n_sec;
    logic [HUE_W-1:0] n_base;
    logic [J_W-1:0]   n_f;
    logic [J_W-1:0]   n_jx;

    always_comb begin
        n_hw = (i_hsv.hue >= HUE_W'(FULL_TURN)) ? i_hsv.hue - HUE_W'(FULL_TURN)
                                                : i_hsv.hue;
        if (n_hw >= HUE_W'(5 * SECTOR_UNITS)) begin
            n_sec = SEC_RBG;
        end else if (n_hw >= HUE_W'(4 * SECTOR_UNITS)) begin
            n_sec = SEC_BRG;
        end else if (n_hw >= HUE_W'(3 * SECTOR_UNITS)) begin
            n_sec = SEC_BGR;
        end else if (n_hw >= HUE_W'(2 * SECTOR_UNITS)) begin
            n_sec = SEC_GBR;
        end else if (n_hw >= HUE_W'(SECTOR_UNITS)) begin
            n_sec = SEC_GRB;
        end else begin
            n_sec = SEC_RGB;
        end
        case (n_sec)
            SEC_RGB: n_base = '0;
            SEC_GRB: n_base = HUE_W'(SECTOR_UNITS);
            SEC_GBR: n_base = HUE_W'(2 * SECTOR_UNITS);
            SEC_BGR: n_base = HUE_W'(3 * SECTOR_UNITS);
            SEC_BRG: n_base = HUE_W'(4 * SECTOR_UNITS);
            SEC_RBG: n_base = HUE_W'(5 * SECTOR_UNITS);
            default: n_base = '0;
        endcase
        n_f  = J_W'(n_hw - n_base);
        // odd sectors fall, even sectors rise
        n_jx = n_sec[0] ? n_f : J_W'(SECTOR_UNITS) - n_f;
    end

    t_sector        r_sec1, r_sec2, r_sec3, r_sec4;
    logic [CH_W-1:0] r_v1, r_v2, r_v3, r_v4;
    logic [CH_W-1:0] r_s1;
    logic [J_W-1:0]  r_jx1;

    // ---------------- stage 2: a = D - S*j ----------------
    logic [NL-1:0][A_W-1:0] n_a, r_a2;
    // ---------------- stage 3: x = V*a + D/2 ----------------
    logic [NL-1:0][NUM_W-1:0] n_x, r_x3, r_x4;
    // ---------------- stage 4: quotient estimate ----------------
    logic [NL-1:0][NUM_W+RECIP_W-1:0] n_prod;
    logic [NL-1:0][CH_W-1:0]          r_qe4;
    // ---------------- stage 5: fix-up ----------------
    logic [NL-1:0][NUM_W-1:0] n_rem;
    logic [NL-1:0][CH_W-1:0]  n_q;
    t_rgb                     n_rgb, r_rgb;

    always_comb begin
        n_a[0] = A_W'(SCALE_D) - A_W'(r_s1 * r_jx1);
        n_a[1] = A_W'(SCALE_D) - A_W'(r_s1 * J_W'(SECTOR_UNITS));
        for (int i = 0; i < NL; i++) begin
            n_x[i]    = NUM_W'(r_v2 * r_a2[i]) + NUM_W'(SCALE_D / 2);
            n_prod[i] = r_x3[i] * RECIP;
            n_rem[i]  = r_x4[i] - NUM_W'(r_qe4[i] * A_W'(SCALE_D));
            n_q[i]    = (n_rem[i] >= NUM_W'(SCALE_D)) ? r_qe4[i] + CH_W'(1)
                                                       : r_qe4[i];
        end
        // chroma channel rounds to exactly V
        case (r_sec4)
            SEC_RGB: n_rgb = '{red: r_v4,   green: n_q[0], blue: n_q[1]};
            SEC_GRB: n_rgb = '{red: n_q[0], green: r_v4,   blue: n_q[1]};
            SEC_GBR: n_rgb = '{red: n_q[1], green: r_v4,   blue: n_q[0]};
            SEC_BGR: n_rgb = '{red: n_q[1], green: n_q[0], blue: r_v4};
            SEC_BRG: n_rgb = '{red: n_q[0], green: n_q[1], blue: r_v4};
            default: n_rgb = '{red: r_v4,   green: n_q[1], blue: n_q[0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sec1 <= n_sec;
        r_v1   <= i_hsv.brightness;
        r_s1   <= i_hsv.saturation;
        r_jx1  <= n_jx;

        r_sec2 <= r_sec1;
        r_v2   <= r_v1;
        r_a2   <= n_a;

        r_sec3 <= r_sec2;
        r_v3   <= r_v2;
        r_x3   <= n_x;

        r_sec4 <= r_sec3;
        r_v4   <= r_v3;
        r_x4   <= r_x3;
        for (int i = 0; i < NL; i++) begin
            r_qe4[i] <= n_prod[i][RECIP_SHIFT +: CH_W];
        end

        r_rgb  <= n_rgb;
    end

    assign o_rgb = r_rgb;

`ifndef ASSERT_OFF
    // Every result beat traces back to an accepted pixel.
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 5))
        else $error("result beat without matching input beat");

    // Zero saturation gives a grey pixel.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_hsv.saturation, 5) == '0) |->
            (o_rgb.red == o_rgb.green && o_rgb.green == o_rgb.blue))
        else $error("zero saturation did not give grey");

    // Largest channel equals the HSV value; none exceeds it.
    a_max_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |->
            (o_rgb.red   <= $past(i_hsv.brightness, 5) &&
             o_rgb.green <= $past(i_hsv.brightness, 5) &&
             o_rgb.blue  <= $past(i_hsv.brightness, 5) &&
             (o_rgb.red   == $past(i_hsv.brightness, 5) ||
              o_rgb.green == $past(i_hsv.brightness, 5) ||
              o_rgb.blue  == $past(i_hsv.brightness, 5))))
        else $error("channel bound by value violated");

    // Once out of reset the pipeline never refuses a beat.
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");
`endif

endmodule
